// ===== design/printable_string_pattern_scanner_core_defines.svh =====
// Assertion macros for the printable string pattern scanner.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PRINTABLE_STRING_PATTERN_SCANNER_CORE_DEFINES_SVH
`define PRINTABLE_STRING_PATTERN_SCANNER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define PSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PSS_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSS_ASSERT(lbl, clk, rst, prop, msg)
`define PSS_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== design/pss_pkg.sv =====
// Shared types, constants and helper functions for the pattern scanner.
// No dependencies.
package pss_pkg;
   localparam int AddrWidth    = 48;
   localparam int DisplayChars = 1024;
   localparam int PatternMax   = 16;
   localparam int HitDepth     = 16;
   localparam int MinPattern   = 4;
   localparam int StringLimit  = 100;
   localparam int OffWidth     = $clog2(DisplayChars);
   localparam int HitIdxWidth  = $clog2(HitDepth);
   localparam int HitCntWidth  = $clog2(HitDepth + 1);

   typedef enum logic [1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2,
      CSR_DETECT_WIDE    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      EM_IDLE,
      EM_READ,
      EM_LOAD,
      EM_SHOW
   } emit_state_type;

   typedef struct packed {
      logic                   we;
      logic [HitIdxWidth-1:0] addr;
      logic [OffWidth-1:0]    data;
   } hit_write_type;

   typedef struct packed {
      logic                   start;
      logic [HitCntWidth-1:0] count;
      logic [AddrWidth-1:0]   saddr;
      logic                   wide;
      logic [4:0]             len;
   } emit_job_type;

   function automatic logic is_printable(input logic [7:0] b);
      return (b == 8'h09) || (b >= 8'h20 && b <= 8'h7E);
   endfunction

   function automatic logic [7:0] pattern_char(input logic [127:0] pat,
                                               input logic [3:0] idx);
      return pat[idx*8 +: 8];
   endfunction
endpackage

// ===== design/pss_emitter.sv =====
// Hit offset memory and result emitter: reads stored occurrences after a run closes.
// Depends on pss_pkg.
module pss_emitter (
   input  logic                  clock,
   input  logic                  reset,
   input  pss_pkg::hit_write_type hit_wr,
   input  pss_pkg::emit_job_type job,
   output logic                  idle,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [111:0]          rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   import pss_pkg::*;

   logic [OffWidth-1:0]    mem [HitDepth];
   logic [OffWidth-1:0]    rd_data_ff;
   emit_state_type         state_ff, state_in;
   logic [HitIdxWidth-1:0] k_ff, k_in;
   logic [HitCntWidth-1:0] count_ff;
   logic [AddrWidth-1:0]   saddr_ff;
   logic                   wide_ff;
   logic [4:0]             len_ff;
   logic [AddrWidth-1:0]   hit_ff, hit_in;
   logic                   last_ff, last_in;
   logic                   load;

   always_ff @(posedge clock) begin
      if (hit_wr.we) begin
         mem[hit_wr.addr] <= hit_wr.data;
      end
      rd_data_ff <= mem[k_ff];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EM_IDLE: if (job.start) state_in = EM_READ;
         EM_READ: state_in = EM_LOAD;
         EM_LOAD: state_in = EM_SHOW;
         EM_SHOW: if (rsp_tready) state_in = last_ff ? EM_IDLE : EM_READ;
         default: state_in = EM_IDLE;
      endcase
   end

   always_comb begin
      load   = (state_ff == EM_LOAD);
      idle   = (state_ff == EM_IDLE);
      k_in   = k_ff;
      if (state_ff == EM_IDLE) begin
         k_in = '0;
      end else if (state_ff == EM_SHOW && rsp_tready && !last_ff) begin
         k_in = k_ff + 1'b1;
      end
      hit_in  = saddr_ff + (wide_ff ? {{(AddrWidth-OffWidth-1){1'b0}}, rd_data_ff, 1'b0}
                                    : {{(AddrWidth-OffWidth){1'b0}}, rd_data_ff});
      last_in = ({1'b0, k_ff} + 1'b1) == count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EM_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job.start && state_ff == EM_IDLE) begin
         count_ff <= job.count;
         saddr_ff <= job.saddr;
         wide_ff  <= job.wide;
         len_ff   <= job.len;
      end
      if (load) begin
         hit_ff  <= hit_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = (state_ff == EM_SHOW);
   assign rsp_tdata  = {11'd0, len_ff, saddr_ff, hit_ff};
   assign rsp_tuser  = wide_ff;
   assign rsp_tlast  = last_ff;
endmodule

// ===== design/pss_scanner.sv =====
// Per-byte run tracker and sequential pattern matcher with configuration registers.
// Depends on pss_pkg.
module pss_scanner (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [1:0]             csr_addr,
   input  logic [63:0]            csr_wdata,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic [47:0]            byte_address,
   input  logic                   block_start,
   output pss_pkg::hit_write_type hit_wr,
   output pss_pkg::emit_job_type  job
);
   import pss_pkg::*;

   logic [127:0] pat_ff;
   logic [4:0]   len_ff;
   logic         dw_ff;
   logic [7:0]   b0_ff, b0_in, b1_ff, b1_in;
   logic         p0_ff, p0_in, p1_ff, p1_in;
   logic [15:0]  rl_ff, rl_in;
   logic [4:0]   mi_ff, mi_in;
   logic         seen_ff, seen_in;
   logic [HitCntWidth-1:0] hc_ff, hc_in;
   logic [6:0]   sr_ff, sr_in;
   logic         stop_ff, stop_in;

   function automatic logic [4:0] feed_mi(input logic [127:0] pat, input logic [4:0] len,
                                          input logic [7:0] c, input logic [4:0] mi);
      logic ok;
      ok = (len >= 5'(MinPattern)) && (len <= 5'(PatternMax)) && (mi < len);
      if (ok && c == pattern_char(pat, mi[3:0]) && (mi + 5'd1) < len) return mi + 5'd1;
      return 5'd0;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff <= '0;
         len_ff <= '0;
         dw_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_PATTERN_LOW:    pat_ff[63:0]   <= csr_wdata;
            CSR_PATTERN_HIGH:   pat_ff[127:64] <= csr_wdata;
            CSR_PATTERN_LENGTH: len_ff         <= csr_wdata[4:0];
            CSR_DETECT_WIDE:    dw_ff          <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic p, pp1, pp2, valid, do_app, do_close, wide, seen_c, rep;
      logic [7:0]  bb1;
      logic [15:0] crl;
      logic [16:0] bytes;
      logic [5:0]  mi1;
      b0_in = b0_ff; b1_in = b1_ff; p0_in = p0_ff; p1_in = p1_ff;
      rl_in = rl_ff; mi_in = mi_ff; seen_in = seen_ff; hc_in = hc_ff;
      sr_in = sr_ff; stop_in = stop_ff;
      hit_wr = '0;
      job    = '0;
      do_app = 1'b0; do_close = 1'b0; crl = rl_ff;
      valid = (len_ff >= 5'(MinPattern)) && (len_ff <= 5'(PatternMax));
      p = is_printable(data_byte);
      wide = 1'b0; seen_c = 1'b0; rep = 1'b0; bytes = '0; mi1 = '0;
      pp1 = 1'b0; pp2 = 1'b0; bb1 = '0;
      if (accept) begin
         if (block_start) begin
            b0_in = '0; b1_in = '0; p0_in = 1'b0; p1_in = 1'b0;
            rl_in = '0; mi_in = '0; seen_in = 1'b0; hc_in = '0; stop_in = 1'b0;
         end
         if (!stop_in) begin
            pp1 = p0_in; pp2 = p1_in; bb1 = b0_in;
            unique case ({pp2, pp1, p})
               3'b111: do_app = 1'b1;
               3'b110: begin
                  if (rl_in >= {11'd0, len_ff}) begin
                     do_close = 1'b1; crl = rl_in;
                  end else if (data_byte == 8'd0) begin
                     rl_in = 16'd1; seen_in = 1'b0; hc_in = '0;
                     mi_in = feed_mi(pat_ff, len_ff, bb1, 5'd0);
                  end else begin
                     rl_in = '0; mi_in = '0; seen_in = 1'b0; hc_in = '0;
                  end
               end
               3'b101: do_app = (bb1 == 8'd0);
               3'b100: begin
                  if (rl_in >= {11'd0, len_ff}) begin
                     do_close = 1'b1; crl = rl_in;
                  end else begin
                     rl_in = '0; mi_in = '0; seen_in = 1'b0; hc_in = '0;
                  end
               end
               3'b011: begin
                  if ({1'b0, rl_in} >= {12'd0, len_ff} + 17'd1) begin
                     do_close = 1'b1; crl = rl_in - 16'd1;
                  end else begin
                     rl_in = 16'd2; seen_in = 1'b0; hc_in = '0;
                     mi_in = feed_mi(pat_ff, len_ff, data_byte,
                                     feed_mi(pat_ff, len_ff, bb1, 5'd0));
                  end
               end
               3'b001: do_app = 1'b1;
               default: ;
            endcase
            if (do_app) begin
               if (rl_in < 16'(DisplayChars)) begin
                  if (valid && mi_in < len_ff &&
                      data_byte == pattern_char(pat_ff, mi_in[3:0])) begin
                     if (mi_in + 5'd1 >= len_ff) begin
                        if (hc_in < HitCntWidth'(HitDepth)) begin
                           hit_wr.we   = 1'b1;
                           hit_wr.addr = hc_in[HitIdxWidth-1:0];
                           hit_wr.data = OffWidth'(rl_in + 16'd1 - {11'd0, len_ff});
                           hc_in = hc_in + 1'b1;
                        end
                        seen_in = 1'b1;
                        mi_in   = '0;
                     end else begin
                        mi_in = mi_in + 5'd1;
                     end
                  end else begin
                     mi_in = '0;
                  end
               end
               if (rl_in != 16'hFFFF) rl_in = rl_in + 16'd1;
            end
            if (do_close) begin
               mi1    = {1'b0, mi_in} + 6'd1;
               seen_c = seen_in || (len_ff != 5'd0 && mi1 >= {1'b0, len_ff});
               wide   = (pp1 == p);
               bytes  = wide ? {crl, 1'b0} : {1'b0, crl};
               rep    = seen_c && valid && (!wide || dw_ff);
               if (rep) begin
                  job.start = (hc_in != '0);
                  job.count = hc_in;
                  job.saddr = byte_address - {47'd0, p} - {31'd0, bytes};
                  job.wide  = wide;
                  job.len   = len_ff;
                  if (sr_in != 7'd127) sr_in = sr_in + 7'd1;
               end
               rl_in = '0; mi_in = '0; seen_in = 1'b0; hc_in = '0;
               if (sr_in > 7'(StringLimit)) stop_in = 1'b1;
            end
            if (!stop_in) begin
               b1_in = b0_in; b0_in = data_byte;
               p1_in = pp1;   p0_in = p;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= '0; b1_ff <= '0; p0_ff <= 1'b0; p1_ff <= 1'b0;
         rl_ff <= '0; mi_ff <= '0; seen_ff <= 1'b0; hc_ff <= '0;
         sr_ff <= '0; stop_ff <= 1'b0;
      end else begin
         b0_ff <= b0_in; b1_ff <= b1_in; p0_ff <= p0_in; p1_ff <= p1_in;
         rl_ff <= rl_in; mi_ff <= mi_in; seen_ff <= seen_in; hc_ff <= hc_in;
         sr_ff <= sr_in; stop_ff <= stop_in;
      end
   end
endmodule

// ===== design/printable_string_pattern_scanner_core.sv =====
// Channel  Dir  Handshake          Payload
// req      in   tvalid/tready      tdata: data_byte, byte_address; tuser: block_start
// rsp      out  tvalid/tready      tdata: hit_address, string_address, pattern_length;
//                                  tuser: is_wide; tlast: last_hit
// csr      in   csr_we             csr_addr, csr_wdata
// One byte per cycle while no results are pending. A run close with n stored hits
// holds req_tready low until each hit is read from the hit RAM, loaded and taken at the output.
// Synchronous active-high reset; no clearing pass. Depends on pss_pkg.
module printable_string_pattern_scanner_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,  // data_byte[7:0], byte_address[55:8]
   input  logic         req_tuser,  // block_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,  // hit_address[47:0], string_address[95:48],
                                    // pattern_length[111:96]
   output logic         rsp_tuser,  // is_wide
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [63:0]  csr_wdata
);
   import pss_pkg::*;
   `include "printable_string_pattern_scanner_core_defines.svh"

   hit_write_type hit_wr;
   emit_job_type  job;
   logic          idle;
   logic          accept;

   assign req_tready = idle;
   assign accept     = req_tvalid & req_tready;

   pss_scanner u_scanner (
      .clock, .reset, .csr_we, .csr_addr, .csr_wdata,
      .accept,
      .data_byte   (req_tdata[7:0]),
      .byte_address(req_tdata[55:8]),
      .block_start (req_tuser),
      .hit_wr, .job
   );

   pss_emitter u_emitter (
      .clock, .reset, .hit_wr, .job, .idle,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

   `PSS_ASSERT(a_ready_excl, clock, reset, req_tready |-> !rsp_tvalid, "input open while emitting")
   `PSS_ASSERT(a_last_frees, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready, "emitter not idle after last")
   `PSS_ASSERT(a_len_min, clock, reset, rsp_tvalid |-> rsp_tdata[111:96] >= 16'd4, "short pattern reported")
endmodule
